[rtl/tdpt_pkg.sv]
package tdpt_pkg;

    // width of the candidate port
    localparam int CAND_WIDTH = 32;

    // first odd trial divisor and the step between divisors
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

    // smallest prime, the one even prime
    localparam int SMALLEST_PRIME = 2;

endpackage

[rtl/trial_division_prime_test.sv]
// Trial-division primality test.
//
// Command channel: drive i_candidate and raise start while busy is low; the
// item is taken at that clock edge and, for an odd value above two, busy
// rises on the next cycle. Only the low WIDTH bits of the candidate are
// tested (all 32 when WIDTH >= 32).
// Result channel: o_valid is high for exactly one cycle with o_is_prime; the
// receiver cannot stall and must take it in that cycle.
// Zero, one and even values other than two are answered without the
// divider, from a result registered at acceptance. Odd values above two run
// a loop of odd trial divisors 3, 5, 7, ... while d <= n / d; every divisor
// uses one bit-serial restoring divider, with a handoff through its start
// and done registers. A 32-bit prime needs about 32768 divisors. Only one
// item is in work at a time; busy stays high until its result strobe.
// A new item may be started in the same cycle as the result strobe.
// Reset (i_rst_n low at a clock edge) abandons any item in work and returns
// to idle with no result pending.
module trial_division_prime_test #(
    parameter int WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [tdpt_pkg::CAND_WIDTH-1:0] i_candidate,
    output logic                           busy,
    output logic                           o_valid,
    output logic                           o_is_prime
);

    localparam int NW = (WIDTH < tdpt_pkg::CAND_WIDTH) ? WIDTH : tdpt_pkg::CAND_WIDTH;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WAIT
    } t_state;

    t_state         r_state, n_state;
    logic [NW-1:0]  r_n, n_n;
    logic [NW-1:0]  r_d, n_d;
    logic           r_div_start, n_div_start;
    logic           r_valid, n_valid;
    logic           r_is_prime, n_is_prime;

    logic [NW-1:0]  cand;
    logic           div_done;
    logic [NW-1:0]  div_quo;
    logic [NW-1:0]  div_rem;

    assign cand = i_candidate[NW-1:0];

    // shared remainder unit
    tdpt_divider #(
        .W (NW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_div_start = 1'b0;
        n_valid     = 1'b0;
        n_is_prime  = r_is_prime;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (cand < NW'(tdpt_pkg::SMALLEST_PRIME)) begin
                        n_valid    = 1'b1;
                        n_is_prime = 1'b0;
                    end else if (cand == NW'(tdpt_pkg::SMALLEST_PRIME)) begin
                        n_valid    = 1'b1;
                        n_is_prime = 1'b1;
                    end else if (!cand[0]) begin
                        n_valid    = 1'b1;
                        n_is_prime = 1'b0;
                    end else begin
                        n_n         = cand;
                        n_d         = NW'(tdpt_pkg::FIRST_DIVISOR);
                        n_div_start = 1'b1;
                        n_state     = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    if (div_quo < r_d) begin
                        // divisor passed the square root: no factor
                        n_valid    = 1'b1;
                        n_is_prime = 1'b1;
                        n_state    = S_IDLE;
                    end else if (div_rem == '0) begin
                        n_valid    = 1'b1;
                        n_is_prime = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        n_d         = r_d + NW'(tdpt_pkg::DIVISOR_STEP);
                        n_div_start = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_valid     <= 1'b0;
            r_is_prime  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_valid     <= n_valid;
            r_is_prime  <= n_is_prime;
        end
        r_n <= n_n;
        r_d <= n_d;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_is_prime = r_is_prime;

endmodule

[rtl/tdpt_divider.sv]
module tdpt_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;
    logic          fits;

    // one restoring step: shift in the next dividend bit, try subtracting
    assign rem_shift = {r_rem, r_quo[W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};
    assign fits      = (rem_shift >= {1'b0, r_dvs});

    // step counter and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    // quotient and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? rem_diff[W-1:0] : rem_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
